### hw/rtl/tvts_pkg.sv
// ----------------------------------------------------------------------------
// Tail variance threshold select: shared package
// Payload types, the command and status groups between controller and
// datapath, and the default sizes.
// ----------------------------------------------------------------------------
package tvts_pkg;

	// Default sizes handed to the top level parameters.
	localparam int BINS_DEF       = 256;
	localparam int COUNT_BITS_DEF = 23;

	// Fixed field widths of the payload.
	localparam int FIELD_W = 23;
	localparam int DEV_W   = 8;

	// Multiplier operand chunk and the widths of the sequencing counters.
	localparam int CHUNK_BITS = 16;
	localparam int CHUNK_W    = 2;
	localparam int BIT_W      = 3;

	typedef struct packed {
		logic [FIELD_W-1:0] count_ch0;
		logic [FIELD_W-1:0] count_ch1;
		logic [FIELD_W-1:0] count_ch2;
		logic               last_bin;
	} in_item_t;

	typedef struct packed {
		logic [DEV_W-1:0] thresh_ch0;
		logic [DEV_W-1:0] thresh_ch1;
		logic [DEV_W-1:0] thresh_ch2;
	} out_item_t;

	// Which product the shared multiplier is building.
	typedef enum logic [1:0] {
		PROD_KK = 2'd0,
		PROD_CQ = 2'd1,
		PROD_SS = 2'd2
	} prod_t;

	typedef struct packed {
		logic               load;
		logic               ch_start;
		logic               acc;
		logic               mul;
		logic               diff;
		logic               root;
		logic               next;
		logic               out_load;
		logic [1:0]         ch;
		prod_t              prod;
		logic [CHUNK_W-1:0] chunk;
		logic [BIT_W-1:0]   bit_sel;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic j_zero;
		logic j_top;
		logic out_free;
	} status_t;

endpackage

### hw/rtl/tvts_datapath.sv
// ----------------------------------------------------------------------------
// Tail variance threshold select: datapath
// Bin store, tail accumulators, chunked multiplier, bitwise deviation search,
// running maximum and the output register.
// ----------------------------------------------------------------------------
module tvts_datapath
	import tvts_pkg::*;
#(
	parameter int BINS       = BINS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_data,
	input  logic      cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic      out_ready,
	output logic      out_valid,
	output out_item_t out_data,
	input  cmd_t      cmd,
	output status_t   st
);

	localparam int IDX_W  = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int CNT_W  = COUNT_BITS + IDX_W;
	localparam int SUM_W  = CNT_W + IDX_W;
	localparam int SQ_W   = CNT_W + 2 * IDX_W;
	localparam int MUL_CHUNKS = (SQ_W + CHUNK_BITS - 1) / CHUNK_BITS;
	localparam int A_W    = SUM_W;
	localparam int B_W    = MUL_CHUNKS * CHUNK_BITS;
	localparam int PW     = (A_W + B_W > 2 * CNT_W + 18) ? A_W + B_W : 2 * CNT_W + 18;
	localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(BINS - 1);

	// Bin store and its registered read port.
	logic [3*COUNT_BITS-1:0] bins_q [BINS];
	logic [3*COUNT_BITS-1:0] rd_q;

	logic [IDX_W-1:0]   bin_idx_q;
	logic [IDX_W-1:0]   top_q;
	logic [IDX_W-1:0]   j_q;
	logic [2*IDX_W-1:0] jsq_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SQ_W-1:0]    sq_q;
	logic [PW-1:0]      kk_q, cq_q, ss_q, d_q, p_q, y_q;
	logic [DEV_W-1:0]   dev_q, best_q, min_q;
	logic [DEV_W-1:0]   res_q [3];
	logic               out_valid_q;
	out_item_t          out_q;

	logic [COUNT_BITS-1:0]          h;
	logic [IDX_W+COUNT_BITS-1:0]    jh;
	logic [2*IDX_W+COUNT_BITS-1:0]  jsqh;
	logic [CNT_W-1:0]               c_eff;
	logic [A_W-1:0]                 a_op;
	logic [B_W-1:0]                 b_op;
	logic [CHUNK_BITS-1:0]          b_chunk;
	logic [A_W+CHUNK_BITS-1:0]      partial;
	logic [PW-1:0]                  shifted;
	logic [PW-1:0]                  cand;
	logic [DEV_W-1:0]               best_nxt;

	// Status towards the controller.
	assign st.last     = in_data.last_bin | (bin_idx_q == TOP_IDX);
	assign st.j_zero   = (j_q == '0);
	assign st.j_top    = (j_q == TOP_IDX);
	assign st.out_free = ~out_valid_q | out_ready;

	// Tail terms of the bin just read.
	assign h     = rd_q[cmd.ch * COUNT_BITS +: COUNT_BITS];
	assign jh    = j_q * h;
	assign jsqh  = jsq_q * h;
	assign c_eff = (cnt_q == '0) ? CNT_W'(1) : cnt_q;

	// One chunk of the selected product per cycle.
	always_comb begin
		unique case (cmd.prod)
			PROD_KK: begin
				a_op = A_W'(c_eff);
				b_op = B_W'(c_eff);
			end
			PROD_CQ: begin
				a_op = A_W'(c_eff);
				b_op = B_W'(sq_q);
			end
			default: begin
				a_op = A_W'(sum_q);
				b_op = B_W'(sum_q);
			end
		endcase
	end

	assign b_chunk = b_op[cmd.chunk * CHUNK_BITS +: CHUNK_BITS];
	assign partial = a_op * b_chunk;
	assign shifted = PW'(partial) << (cmd.chunk * CHUNK_BITS);

	// Candidate square for the deviation bit under test.
	assign cand = p_q + (y_q << ({1'b0, cmd.bit_sel} + 4'd1)) + (kk_q << {cmd.bit_sel, 1'b0});

	// Bin BINS-1 is accumulated but gives no deviation of its own.
	assign best_nxt = (!st.j_top && dev_q > best_q) ? dev_q : best_q;

	// Bin store write and read.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bins_q[bin_idx_q] <= {in_data.count_ch2[COUNT_BITS-1:0],
				in_data.count_ch1[COUNT_BITS-1:0], in_data.count_ch0[COUNT_BITS-1:0]};
		end
		rd_q <= bins_q[j_q];
	end

	// Control registers: bin index, threshold floor, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_idx_q   <= '0;
			min_q       <= DEV_W'(10);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				min_q <= cfg_wdata;
			end
			if (cmd.load) begin
				bin_idx_q <= st.last ? '0 : bin_idx_q + IDX_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the tail walk.
	always_ff @(posedge clk) begin
		jsq_q <= j_q * j_q;
		if (cmd.load && st.last) begin
			top_q <= bin_idx_q;
		end
		if (cmd.ch_start) begin
			j_q    <= top_q;
			cnt_q  <= '0;
			sum_q  <= '0;
			sq_q   <= '0;
			best_q <= min_q;
		end
		if (cmd.acc) begin
			cnt_q <= cnt_q + CNT_W'(h);
			sum_q <= sum_q + SUM_W'(jh);
			sq_q  <= sq_q + SQ_W'(jsqh);
		end
		if (cmd.mul) begin
			case (cmd.prod)
				PROD_KK: kk_q <= ((cmd.chunk == '0) ? '0 : kk_q) + shifted;
				PROD_CQ: cq_q <= ((cmd.chunk == '0) ? '0 : cq_q) + shifted;
				default: ss_q <= ((cmd.chunk == '0) ? '0 : ss_q) + shifted;
			endcase
		end
		if (cmd.diff) begin
			d_q   <= cq_q - ss_q;
			p_q   <= '0;
			y_q   <= '0;
			dev_q <= '0;
		end
		if (cmd.root && cand <= d_q) begin
			p_q                <= cand;
			y_q                <= y_q + (kk_q << cmd.bit_sel);
			dev_q[cmd.bit_sel] <= 1'b1;
		end
		if (cmd.next) begin
			best_q <= best_nxt;
			if (st.j_zero) begin
				res_q[cmd.ch] <= best_nxt;
			end else begin
				j_q <= j_q - IDX_W'(1);
			end
		end
		if (cmd.out_load) begin
			out_q.thresh_ch0 <= res_q[0];
			out_q.thresh_ch1 <= res_q[1];
			out_q.thresh_ch2 <= res_q[2];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### hw/rtl/tvts_ctrl.sv
// ----------------------------------------------------------------------------
// Tail variance threshold select: controller
// Sequences loading, the per-channel tail walk, the chunked products and the
// bitwise deviation search.
// ----------------------------------------------------------------------------
module tvts_ctrl
	import tvts_pkg::*;
#(
	parameter int BINS       = BINS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output cmd_t    cmd,
	input  status_t st
);

	localparam int IDX_W      = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int SQ_W       = COUNT_BITS + 3 * IDX_W;
	localparam int MUL_CHUNKS = (SQ_W + CHUNK_BITS - 1) / CHUNK_BITS;
	localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(MUL_CHUNKS - 1);
	localparam logic [BIT_W-1:0]   TOP_BIT    = BIT_W'(DEV_W - 1);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_CH_START = 8'b0000_0010,
		S_READ     = 8'b0000_0100,
		S_ACC      = 8'b0000_1000,
		S_MUL      = 8'b0001_0000,
		S_DIFF     = 8'b0010_0000,
		S_ROOT     = 8'b0100_0000,
		S_NEXT     = 8'b1000_0000
	} state_t;

	state_t             state_q, state_nxt;
	logic [1:0]         ch_q;
	prod_t              prod_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic [BIT_W-1:0]   bit_q;
	logic               finish_q;

	assign in_ready = (state_q == S_IDLE) && !finish_q;

	// Commands follow the state directly.
	always_comb begin
		cmd          = '0;
		cmd.ch       = ch_q;
		cmd.prod     = prod_q;
		cmd.chunk    = chunk_q;
		cmd.bit_sel  = bit_q;
		cmd.load     = in_ready && in_valid;
		cmd.ch_start = (state_q == S_CH_START);
		cmd.acc      = (state_q == S_ACC);
		cmd.mul      = (state_q == S_MUL);
		cmd.diff     = (state_q == S_DIFF);
		cmd.root     = (state_q == S_ROOT);
		cmd.next     = (state_q == S_NEXT);
		cmd.out_load = finish_q && st.out_free;
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_ready && in_valid && st.last) begin
					state_nxt = S_CH_START;
				end
			end
			S_CH_START: state_nxt = S_READ;
			S_READ:     state_nxt = S_ACC;
			S_ACC:      state_nxt = st.j_top ? S_NEXT : S_MUL;
			S_MUL: begin
				if (chunk_q == LAST_CHUNK && prod_q == PROD_SS) begin
					state_nxt = S_DIFF;
				end
			end
			S_DIFF: state_nxt = S_ROOT;
			S_ROOT: begin
				if (bit_q == '0) begin
					state_nxt = S_NEXT;
				end
			end
			S_NEXT: begin
				if (!st.j_zero) begin
					state_nxt = S_READ;
				end else if (ch_q == 2'd2) begin
					state_nxt = S_IDLE;
				end else begin
					state_nxt = S_CH_START;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// State and loop counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ch_q     <= '0;
			prod_q   <= PROD_KK;
			chunk_q  <= '0;
			bit_q    <= '0;
			finish_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_IDLE && in_ready && in_valid && st.last) begin
				ch_q <= '0;
			end
			if (state_q == S_ACC) begin
				prod_q  <= PROD_KK;
				chunk_q <= '0;
			end
			if (state_q == S_MUL) begin
				if (chunk_q == LAST_CHUNK) begin
					chunk_q <= '0;
					prod_q  <= (prod_q == PROD_KK) ? PROD_CQ : PROD_SS;
				end else begin
					chunk_q <= chunk_q + CHUNK_W'(1);
				end
			end
			if (state_q == S_DIFF) begin
				bit_q <= TOP_BIT;
			end
			if (state_q == S_ROOT) begin
				bit_q <= bit_q - BIT_W'(1);
			end
			if (state_q == S_NEXT && st.j_zero) begin
				if (ch_q == 2'd2) begin
					finish_q <= 1'b1;
				end else begin
					ch_q <= ch_q + 2'd1;
				end
			end
			if (finish_q && st.out_free) begin
				finish_q <= 1'b0;
			end
		end
	end

endmodule

### hw/rtl/tail_variance_threshold_select_core.sv
// ----------------------------------------------------------------------------
// Tail variance threshold select: top level
// Takes three channel histograms one bin per beat and returns one threshold
// per channel for each histogram.
// ----------------------------------------------------------------------------
// Each input beat writes one bin. The beat that carries last_bin,
// or the beat at bin BINS-1, starts the evaluation, during which no beat is
// taken: for each of the three channels the tail is walked from the top bin
// down, with a store read and an accumulation step for every bin, plus for
// every bin below BINS-1 three products on one shared chunked multiplier,
// each in ceil((COUNT_BITS + 3*log2(BINS)) / 16) chunks, a step to form the
// variance term and a bitwise deviation search from the top deviation bit
// down, then a step for the running maximum. The result waits in an output
// register, so loading of the next histogram may start before it is taken.
module tail_variance_threshold_select_core
	import tvts_pkg::*;
#(
	parameter int BINS       = BINS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	cmd_t    cmd;
	status_t st;

	// Sequencer.
	tvts_ctrl #(
		.BINS       (BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.st       (st)
	);

	// Arithmetic and storage.
	tvts_datapath #(
		.BINS       (BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.st        (st)
	);

endmodule

### hw/rtl/tvts_checker.sv
// ----------------------------------------------------------------------------
// Tail variance threshold select: port checker
// Watches the top level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module tvts_port_checker
	import tvts_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input in_item_t   in_data,
	input logic       out_valid,
	input logic       out_ready,
	input out_item_t  out_data
);

	// A waiting result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat withdrawn before it was taken");

	// A waiting result beat keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result payload changed while stalled");

	// A beat with last_bin starts the evaluation, which blocks input.
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last_bin |=> !in_ready)
		else $error("input still taken after the closing bin");

	// A new result only appears after an evaluation has run.
	a_result_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without an evaluation");

endmodule

bind tail_variance_threshold_select_core tvts_port_checker u_tvts_port_checker (.*);

### sim/tvts_checker.sv
// ----------------------------------------------------------------------------
// Tail variance threshold select: checker
// Watches the input, output and register ports of the block, keeps its own
// copy of the histogram store and of the floor register, predicts the three
// channel thresholds for every closed histogram and compares each result beat
// with the oldest prediction.
// ----------------------------------------------------------------------------
module tvts_checker
	import tvts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	output int        errors,
	output int        pending
);

	localparam int NBINS = 256;

	logic [FIELD_W-1:0] hist [3][NBINS];
	logic [7:0]         next_bin;
	logic [7:0]         floor_thr;
	out_item_t          thresholds_due [$];

	// Largest d with (d*c)^2 + s^2 <= c*q, searched bit by bit.
	function automatic logic [7:0] tail_deviation(logic [63:0] c, logic [63:0] s,
		logic [63:0] q);
		logic [127:0] rhs;
		logic [127:0] s2;
		logic [127:0] dc;
		logic [7:0]   d;
		logic [7:0]   cand;
		int           b;
		rhs = 128'(c) * 128'(q);
		s2  = 128'(s) * 128'(s);
		d   = '0;
		for (b = 7; b >= 0; b--) begin
			cand = d | (8'd1 << b);
			dc   = 128'(cand) * 128'(c);
			if (dc * dc + s2 <= rhs) begin
				d = cand;
			end
		end
		return d;
	endfunction

	// Walk the tail of one channel from the top bin down, keeping the maximum.
	function automatic logic [7:0] channel_select(int ch, int top);
		logic [63:0] cnt;
		logic [63:0] sum;
		logic [63:0] sq;
		logic [63:0] h;
		logic [7:0]  best;
		logic [7:0]  d;
		int          j;
		cnt  = '0;
		sum  = '0;
		sq   = '0;
		best = floor_thr;
		for (j = top; j >= 0; j--) begin
			h    = 64'(hist[ch][j]);
			cnt  = cnt + h;
			sum  = sum + 64'(j) * h;
			sq   = sq + 64'(j) * 64'(j) * h;
			// The topmost bin of a full store forms no threshold of its own.
			if (j <= NBINS - 2) begin
				d = tail_deviation((cnt == 0) ? 64'd1 : cnt, sum, sq);
				if (d > best) begin
					best = d;
				end
			end
		end
		return best;
	endfunction

	assign pending = thresholds_due.size();

	// Track the register, store every input beat and compare every result beat.
	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_item;
		int        idx;
		logic      closes;
		int        bad;
		if (!arst_n) begin
			next_bin  <= '0;
			floor_thr <= 8'd10;
			errors    <= 0;
		end else begin
			bad = 0;
			if (cfg_we) begin
				floor_thr <= cfg_wdata;
			end
			if (out_valid && out_ready) begin
				if (thresholds_due.size() == 0) begin
					$error("result beat with no histogram outstanding: %h", out_data);
					bad++;
				end else begin
					exp_item = thresholds_due.pop_front();
					if (out_data.thresh_ch0 !== exp_item.thresh_ch0) begin
						$error("thresh_ch0 expected %0d actual %0d",
							exp_item.thresh_ch0, out_data.thresh_ch0);
						bad++;
					end
					if (out_data.thresh_ch1 !== exp_item.thresh_ch1) begin
						$error("thresh_ch1 expected %0d actual %0d",
							exp_item.thresh_ch1, out_data.thresh_ch1);
						bad++;
					end
					if (out_data.thresh_ch2 !== exp_item.thresh_ch2) begin
						$error("thresh_ch2 expected %0d actual %0d",
							exp_item.thresh_ch2, out_data.thresh_ch2);
						bad++;
					end
				end
			end
			if (bad != 0) begin
				errors <= errors + bad;
			end
			if (in_valid && in_ready) begin
				idx = int'(next_bin);
				hist[0][idx] = in_data.count_ch0;
				hist[1][idx] = in_data.count_ch1;
				hist[2][idx] = in_data.count_ch2;
				closes = in_data.last_bin || (idx == NBINS - 1);
				if (closes) begin
					exp_item.thresh_ch0 = channel_select(0, idx);
					exp_item.thresh_ch1 = channel_select(1, idx);
					exp_item.thresh_ch2 = channel_select(2, idx);
					thresholds_due.push_back(exp_item);
					next_bin <= '0;
				end else begin
					next_bin <= next_bin + 8'd1;
				end
			end
		end
	end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Tail variance threshold select: testbench top
// Feeds histograms of assorted lengths and count patterns through the block
// under several floor settings and idling phases, including a long output
// hold-off, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
	import tvts_pkg::*;

	localparam int MAX_COUNT = 4194304;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_item_t  out_data;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	int         errors;
	int         pending;

	int   send_idle_pct;
	int   recv_stall_pct;
	logic hold_req;
	logic hold_seen = 1'b0;
	int   hold_left = 0;
	int   beats_sent;

	tail_variance_threshold_select_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	tvts_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	// Clock with a period of 10.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 30000;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offer one beat and wait for it to be taken.
	task automatic send_beat(logic [22:0] c0, logic [22:0] c1, logic [22:0] c2,
		logic last);
		@(negedge clk);
		if (send_idle_pct > 0) begin
			while ($urandom_range(99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid          <= 1'b1;
		in_data.count_ch0 <= c0;
		in_data.count_ch1 <= c1;
		in_data.count_ch2 <= c2;
		in_data.last_bin  <= last;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		beats_sent++;
	endtask

	// Count for one bin: zero, small, MAX_COUNT, or anywhere up to MAX_COUNT.
	function automatic logic [22:0] pick_count(int style);
		int r;
		r = $urandom_range(99);
		case (style)
			0: return '0;
			1: return 23'(MAX_COUNT);
			default: begin
				if (r < 25) return '0;
				else if (r < 50) return 23'($urandom_range(15));
				else if (r < 60) return 23'(MAX_COUNT);
				else return 23'($urandom_range(MAX_COUNT));
			end
		endcase
	endfunction

	// One histogram of len bins; a full one may close on its index alone.
	task automatic send_histogram(int len, int style, logic flag_end);
		int i;
		for (i = 0; i < len; i++) begin
			send_beat(pick_count(style), pick_count(style), pick_count(style),
				(i == len - 1) && flag_end);
		end
	endtask

	// Withdraw the input, then wait until every result has been taken.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic write_floor(logic [7:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic random_histograms(int beats);
		int target;
		int r;
		target = beats_sent + beats;
		while (beats_sent < target) begin
			r = $urandom_range(199);
			if (r == 0) send_histogram(256, 2, 1'b0);
			else if (r < 10) send_histogram(1, 2, 1'b1);
			else if (r < 16) send_histogram($urandom_range(2, 12), 0, 1'b1);
			else if (r < 22) send_histogram($urandom_range(2, 12), 1, 1'b1);
			else send_histogram($urandom_range(2, 12), 2, 1'b1);
		end
	endtask

	// Stimulus: directed histograms, then random phases under varied floors.
	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		hold_req       = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		beats_sent     = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: single bin, MAX_COUNT counts, empty tails, mixed.
		send_histogram(1, 1, 1'b1);
		send_histogram(2, 1, 1'b1);
		send_histogram(3, 0, 1'b1);
		send_beat(23'(MAX_COUNT), '0, 23'd1, 1'b0);
		send_beat('0, 23'(MAX_COUNT), '0, 1'b0);
		send_beat(23'd1, '0, 23'(MAX_COUNT), 1'b0);
		send_beat(23'd7, 23'd1, '0, 1'b1);
		send_histogram(8, 2, 1'b1);
		drain();

		// Floor at zero, no idling; includes a full histogram closed by index.
		write_floor(8'd0);
		send_histogram(256, 2, 1'b0);
		random_histograms(200);
		drain();

		// Floor at its largest, sender mostly idle.
		write_floor(8'd255);
		send_idle_pct = 86;
		random_histograms(250);
		drain();

		// Random floor, receiver mostly stalling.
		write_floor(8'($urandom_range(0, 40)));
		send_idle_pct  = 0;
		recv_stall_pct = 86;
		random_histograms(300);
		drain();

		// Long output hold-off while the sender keeps offering.
		write_floor(8'd1);
		recv_stall_pct = 0;
		hold_req       = 1'b1;
		random_histograms(150);
		drain();

		// Back to the reset floor, both sides idling now and then.
		write_floor(8'd10);
		send_idle_pct  = 19;
		recv_stall_pct = 19;
		send_histogram(256, 2, 1'b1);
		random_histograms(300);
		drain();

		write_floor(8'($urandom_range(0, 255)));
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		random_histograms(100);

		@(negedge clk);
		in_valid <= 1'b0;
		drain();
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#30000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
